[hdl/lcps_pkg.sv]
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types, widths, register indexes and reset values of the line
// centroid PID steering unit.
// ----------------------------------------------------------------------------
package lcps_pkg;

  localparam int WINDOW_LENGTH_DEF     = 30;
  localparam int MAX_REGION_PIXELS_DEF = 2097152;

  localparam int CNT_W    = 22;
  localparam int XSUM_W   = 32;
  localparam int FRAC_W   = 8;
  localparam int DVD_W    = XSUM_W + FRAC_W;
  localparam int CX_W     = 20;
  localparam int COL_W    = 11;
  localparam int ERR_W    = 21;
  localparam int DE_W     = 22;
  localparam int GAIN_W   = 32;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 64;
  localparam int STEER_W  = 16;
  localparam int STOP_W   = 8;
  localparam int RUN_W    = 8;
  localparam int ROUND_SH = 24;
  localparam int PIXLIM_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP          = 3'd0,
    CFG_KI_DT       = 3'd1,
    CFG_KD          = 3'd2,
    CFG_CENTER      = 3'd3,
    CFG_STEER_MIN   = 3'd4,
    CFG_STEER_MAX   = 3'd5,
    CFG_STOP_FRAMES = 3'd6
  } cfg_idx_t;

  localparam logic signed [GAIN_W-1:0]  KP_RST        = 32'sd1677722;
  localparam logic signed [GAIN_W-1:0]  KI_DT_RST     = 32'sd503;
  localparam logic signed [GAIN_W-1:0]  KD_RST        = 32'sd503316;
  localparam logic [COL_W-1:0]          CENTER_RST    = 11'd770;
  localparam logic signed [STEER_W-1:0] STEER_MIN_RST = -16'sd7680;
  localparam logic signed [STEER_W-1:0] STEER_MAX_RST = 16'sd7680;
  localparam logic [STOP_W-1:0]         STOP_RST      = 8'd5;

  typedef enum logic [1:0] {
    STATUS_SKIP    = 2'd0,
    STATUS_STOP    = 2'd1,
    STATUS_STEER   = 2'd2,
    STATUS_NO_LINE = 2'd3
  } status_t;

  typedef struct packed {
    logic              frame_enabled;
    logic              blue_cluster;
    logic [CNT_W-1:0]  yellow_pixel_count;
    logic [XSUM_W-1:0] yellow_x_sum;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic                       line_found_event;
    logic signed [STEER_W-1:0]  steer_cmd;
  } out_item_t;

endpackage

[hdl/lcps_stream_if.sv]
// ----------------------------------------------------------------------------
// lcps_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lcps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/line_centroid_pid_steering_unit.sv]
// ----------------------------------------------------------------------------
// line_centroid_pid_steering_unit
// Frame-summary to steering command: centroid divide, windowed PID, clamp.
// ----------------------------------------------------------------------------
// One item at a time. A disabled, blue-stop or no-line frame has its result
// valid the cycle after it is taken. A steering frame passes in order through
// the bit-serial centroid divider, the window update, the multiply loop where
// one 32x32 multiplier forms the three gain products, rounding and clamping;
// the divider width sets most of its time. The input is not ready while a
// frame is in work; a new item is taken once the previous result has left, or
// is leaving, the output register.
module line_centroid_pid_steering_unit #(
  parameter int WINDOW_LENGTH     = lcps_pkg::WINDOW_LENGTH_DEF,
  parameter int MAX_REGION_PIXELS = lcps_pkg::MAX_REGION_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lcps_stream_if.sink                       in_stream,
  lcps_stream_if.source                     out_stream,
  input  logic                              cfg_we,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PTR_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = lcps_pkg::ERR_W + FILL_W;
  localparam logic [lcps_pkg::PIXLIM_W-1:0] MaxPix =
    lcps_pkg::PIXLIM_W'(MAX_REGION_PIXELS);
  localparam logic signed [lcps_pkg::ACC_W-1:0] RoundHalf =
    lcps_pkg::ACC_W'(1) << (lcps_pkg::ROUND_SH - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_RND  = 6'b010000,
    ST_SAT  = 6'b100000
  } state_t;

  // configuration
  logic signed [lcps_pkg::GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [lcps_pkg::COL_W-1:0]          center_r;
  logic signed [lcps_pkg::STEER_W-1:0] steer_min_r, steer_max_r;
  logic [lcps_pkg::STOP_W-1:0]         stop_need_r;

  // control and state
  state_t                              state_r;
  logic [lcps_pkg::RUN_W-1:0]          blue_run_r;
  logic [lcps_pkg::RUN_W-1:0]          blue_run_nxt;
  logic                                line_seen_r;
  logic [FILL_W-1:0]                   fill_r;
  logic [PTR_W-1:0]                    ptr_r;
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [lcps_pkg::ERR_W-1:0]   last_err_r;
  logic [1:0]                          mcnt_r;
  logic                                out_valid_r;
  lcps_pkg::out_item_t                 out_item_r;
  logic                                event_r;

  // datapath
  logic signed [lcps_pkg::ERR_W-1:0]   err_win_mem [WINDOW_LENGTH];
  logic signed [lcps_pkg::ERR_W-1:0]   old_err_r;
  logic signed [lcps_pkg::ERR_W-1:0]   e_r;
  logic signed [lcps_pkg::DE_W-1:0]    de_r;
  logic signed [lcps_pkg::PROD_W-1:0]  prod_r;
  logic signed [lcps_pkg::ACC_W-1:0]   acc_r;
  logic signed [lcps_pkg::ACC_W-1:0]   t_r;

  lcps_pkg::in_item_t                  in_item;
  logic                                out_free;
  logic                                out_load;
  logic                                accept;
  logic                                stop_hit;
  logic                                do_steer;
  lcps_pkg::status_t                   quick_status;
  logic [lcps_pkg::CNT_W-1:0]          divisor;
  logic                                div_done;
  logic [lcps_pkg::CX_W-1:0]           cx;
  logic                                win_full;
  logic signed [SUM_W-1:0]             sum_nxt;
  logic signed [lcps_pkg::GAIN_W-1:0]  mul_a;
  logic signed [lcps_pkg::GAIN_W-1:0]  mul_b;
  logic signed [lcps_pkg::ACC_W-1:0]   steer_full;
  logic signed [lcps_pkg::ACC_W-1:0]   steer_hi;
  logic signed [lcps_pkg::ACC_W-1:0]   steer_lo_hi;

  assign in_item         = in_stream.payload;
  assign out_free        = !out_valid_r || out_stream.ready;
  assign in_stream.ready = (state_r == ST_IDLE) && out_free;
  assign accept          = in_stream.valid && in_stream.ready;
  assign out_load        = (accept && !do_steer) || ((state_r == ST_SAT) && out_free);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= lcps_pkg::KP_RST;
      ki_r        <= lcps_pkg::KI_DT_RST;
      kd_r        <= lcps_pkg::KD_RST;
      center_r    <= lcps_pkg::CENTER_RST;
      steer_min_r <= lcps_pkg::STEER_MIN_RST;
      steer_max_r <= lcps_pkg::STEER_MAX_RST;
      stop_need_r <= lcps_pkg::STOP_RST;
    end else if (cfg_we) begin
      case (lcps_pkg::cfg_idx_t'(cfg_index))
        lcps_pkg::CFG_KP:          kp_r        <= cfg_wdata;
        lcps_pkg::CFG_KI_DT:       ki_r        <= cfg_wdata;
        lcps_pkg::CFG_KD:          kd_r        <= cfg_wdata;
        lcps_pkg::CFG_CENTER:      center_r    <= cfg_wdata[lcps_pkg::COL_W-1:0];
        lcps_pkg::CFG_STEER_MIN:   steer_min_r <= cfg_wdata[lcps_pkg::STEER_W-1:0];
        lcps_pkg::CFG_STEER_MAX:   steer_max_r <= cfg_wdata[lcps_pkg::STEER_W-1:0];
        lcps_pkg::CFG_STOP_FRAMES: stop_need_r <= cfg_wdata[lcps_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // frame classification at acceptance
  always_comb begin
    if (!in_item.frame_enabled || !in_item.blue_cluster) begin
      blue_run_nxt = '0;
    end else if (blue_run_r != {lcps_pkg::RUN_W{1'b1}}) begin
      blue_run_nxt = blue_run_r + 1'b1;
    end else begin
      blue_run_nxt = blue_run_r;
    end
    stop_hit = in_item.frame_enabled && in_item.blue_cluster &&
               (blue_run_nxt >= stop_need_r);
    do_steer = in_item.frame_enabled && !stop_hit &&
               (in_item.yellow_pixel_count != '0);
    if (!in_item.frame_enabled) begin
      quick_status = lcps_pkg::STATUS_SKIP;
    end else if (stop_hit) begin
      quick_status = lcps_pkg::STATUS_STOP;
    end else begin
      quick_status = lcps_pkg::STATUS_NO_LINE;
    end
    if ({2'b00, in_item.yellow_pixel_count} > MaxPix) begin
      divisor = MaxPix[lcps_pkg::CNT_W-1:0];
    end else begin
      divisor = in_item.yellow_pixel_count;
    end
  end

  lcps_divider #(
    .DVD_W (lcps_pkg::DVD_W),
    .DVS_W (lcps_pkg::CNT_W),
    .Q_W   (lcps_pkg::CX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && do_steer),
    .dividend ({in_item.yellow_x_sum, {lcps_pkg::FRAC_W{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (cx)
  );

  // error window
  always_ff @(posedge clk) begin
    old_err_r <= err_win_mem[ptr_r];
    if (state_r == ST_UPD) begin
      err_win_mem[ptr_r] <= e_r;
    end
  end

  assign win_full = (fill_r == FILL_W'(WINDOW_LENGTH));
  assign sum_nxt  = sum_r + SUM_W'(e_r) - (win_full ? SUM_W'(old_err_r) : SUM_W'(0));

  // shared multiplier operand select
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mul_a = kp_r;
        mul_b = lcps_pkg::GAIN_W'(e_r);
      end
      2'd1: begin
        mul_a = ki_r;
        mul_b = lcps_pkg::GAIN_W'(sum_r);
      end
      default: begin
        mul_a = kd_r;
        mul_b = lcps_pkg::GAIN_W'(de_r);
      end
    endcase
  end

  // round, then clamp (lower limit applied last)
  assign steer_full  = t_r >>> lcps_pkg::ROUND_SH;
  assign steer_hi    = lcps_pkg::ACC_W'(steer_max_r);
  assign steer_lo_hi = (steer_full > steer_hi) ? steer_hi : steer_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blue_run_r  <= '0;
      line_seen_r <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      last_err_r  <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      event_r     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            blue_run_r <= blue_run_nxt;
            if (stop_hit) begin
              line_seen_r <= 1'b0;
            end
            if (do_steer) begin
              line_seen_r <= 1'b1;
              event_r     <= !line_seen_r;
              state_r     <= ST_DIV;
            end else begin
              out_item_r.status           <= quick_status;
              out_item_r.line_found_event <= 1'b0;
              out_item_r.steer_cmd        <= '0;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            e_r     <= lcps_pkg::ERR_W'(cx) -
                       lcps_pkg::ERR_W'({center_r, {lcps_pkg::FRAC_W{1'b0}}});
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          sum_r      <= sum_nxt;
          de_r       <= lcps_pkg::DE_W'(e_r) - lcps_pkg::DE_W'(last_err_r);
          last_err_r <= e_r;
          if (!win_full) begin
            fill_r <= fill_r + 1'b1;
          end
          if (ptr_r == PTR_W'(WINDOW_LENGTH - 1)) begin
            ptr_r <= '0;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
          acc_r   <= '0;
          mcnt_r  <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= mul_a * mul_b;
          if (mcnt_r != 2'd0) begin
            acc_r <= acc_r + prod_r;
          end
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 2'd3) begin
            state_r <= ST_RND;
          end
        end
        ST_RND: begin
          t_r     <= RoundHalf - acc_r;
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (out_free) begin
            out_item_r.status           <= lcps_pkg::STATUS_STEER;
            out_item_r.line_found_event <= event_r;
            if (steer_lo_hi < lcps_pkg::ACC_W'(steer_min_r)) begin
              out_item_r.steer_cmd <= steer_min_r;
            end else begin
              out_item_r.steer_cmd <= steer_lo_hi[lcps_pkg::STEER_W-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_item_r;

endmodule

[hdl/lcps_divider.sv]
// ----------------------------------------------------------------------------
// lcps_divider
// Radix-2 restoring divider, one quotient bit per cycle, with the quotient
// saturated to its output width.
// ----------------------------------------------------------------------------
module lcps_divider #(
  parameter int DVD_W = lcps_pkg::DVD_W,
  parameter int DVS_W = lcps_pkg::CNT_W,
  parameter int Q_W   = lcps_pkg::CX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             qbit;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign qbit    = ~diff[DVS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = (|dvd_r[DVD_W-1:Q_W]) ? {Q_W{1'b1}} : dvd_r[Q_W-1:0];

endmodule

[hdl/lcps_checker.sv]
// ----------------------------------------------------------------------------
// lcps_checker
// Port-level checks of the steering unit, attached by bind.
// ----------------------------------------------------------------------------
module lcps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_status,
  input logic                              out_event,
  input logic [lcps_pkg::STEER_W-1:0]      out_steer
);

  a_steer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lcps_pkg::STATUS_STEER) |-> (out_steer == '0))
    else $error("steer command nonzero without steering status");

  a_event_steer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event |-> (out_status == lcps_pkg::STATUS_STEER))
    else $error("line event without steering status");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while a result is blocked");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_event) && $stable(out_steer))
    else $error("stalled result changed");

endmodule

bind line_centroid_pid_steering_unit lcps_checker u_lcps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_status (out_stream.payload.status),
  .out_event  (out_stream.payload.line_found_event),
  .out_steer  (out_stream.payload.steer_cmd)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line centroid PID steering unit. A table of
// directed frames and then random frame summaries go in over the valid/ready
// input while both sides stall at random. Each result is checked field by field
// against the expected item of a fixed table row or else an in-bench steering
// predictor, over several gain, limit and stop-threshold settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int PHASES           = 7;
  localparam int FRAMES_PER_PHASE = 268;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES    = 4;
  localparam int DRAIN_CYCLES     = 64;

  typedef struct packed {
    lcps_pkg::in_item_t  frame;
    logic                fixed;
    lcps_pkg::out_item_t want;
  } frame_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lcps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lcps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lcps_stream_if #(.payload_t(lcps_pkg::in_item_t))  in_if ();
  lcps_stream_if #(.payload_t(lcps_pkg::out_item_t)) out_if ();

  line_centroid_pid_steering_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor copy of the configuration
  logic signed [lcps_pkg::GAIN_W-1:0]  kp_q24, kidt_q24, kd_q24;
  logic [lcps_pkg::COL_W-1:0]          center_px;
  logic signed [lcps_pkg::STEER_W-1:0] lim_lo, lim_hi;
  logic [lcps_pkg::STOP_W-1:0]         stop_need;

  // predictor copy of the state
  logic signed [lcps_pkg::ERR_W-1:0] err_hist [lcps_pkg::WINDOW_LENGTH_DEF];
  int unsigned                       hist_fill, hist_ptr;
  longint                            err_total;
  logic signed [lcps_pkg::ERR_W-1:0] prev_err;
  bit                                line_on;
  int unsigned                       blue_count;

  lcps_pkg::out_item_t steer_q [$];
  frame_row_t          typed_q [$];

  int unsigned fail_count, results_seen, frames_sent, cycle_count;
  int unsigned status_tally [4];
  int unsigned event_tally, clamp_hits, settings_used;
  int unsigned blue_left;
  bit src_steady, sink_steady, took_result, long_hold;

  frame_row_t dir_rows [22] = '{
    '{'{1'b0, 1'b0, 22'd0, 32'd0}, 1'b1, '{lcps_pkg::STATUS_SKIP, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd0, 32'd0}, 1'b1, '{lcps_pkg::STATUS_NO_LINE, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd1, 32'd770}, 1'b1, '{lcps_pkg::STATUS_STEER, 1'b1, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd1, 32'd770}, 1'b1, '{lcps_pkg::STATUS_STEER, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd1, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b1, 1'b0, 22'h3F_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b1, 1'b0, 22'd2097152, 32'd0}, 1'b0, '0},
    '{'{1'b1, 1'b0, 22'd2097153, 32'd1000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 22'd1, 32'd0}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b1, '{lcps_pkg::STATUS_STOP, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b1, '{lcps_pkg::STATUS_STOP, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 22'd100, 32'd77000}, 1'b0, '0},
    '{'{1'b0, 1'b1, 22'd100, 32'd77000}, 1'b1, '{lcps_pkg::STATUS_SKIP, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b1, 22'd0, 32'd0}, 1'b1, '{lcps_pkg::STATUS_NO_LINE, 1'b0, 16'sd0}},
    '{'{1'b0, 1'b1, 22'h3F_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{lcps_pkg::STATUS_SKIP, 1'b0, 16'sd0}},
    '{'{1'b1, 1'b0, 22'd3, 32'd1}, 1'b0, '0},
    '{'{1'b1, 1'b0, 22'd640, 32'd492800}, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void clear_model();
    kp_q24     = lcps_pkg::KP_RST;
    kidt_q24   = lcps_pkg::KI_DT_RST;
    kd_q24     = lcps_pkg::KD_RST;
    center_px  = lcps_pkg::CENTER_RST;
    lim_lo     = lcps_pkg::STEER_MIN_RST;
    lim_hi     = lcps_pkg::STEER_MAX_RST;
    stop_need  = lcps_pkg::STOP_RST;
    foreach (err_hist[i]) err_hist[i] = '0;
    hist_fill  = 0;
    hist_ptr   = 0;
    err_total  = 0;
    prev_err   = '0;
    line_on    = 1'b0;
    blue_count = 0;
  endfunction

  function automatic lcps_pkg::out_item_t steer_model(lcps_pkg::in_item_t f);
    lcps_pkg::out_item_t r;
    longint unsigned     pix, cx;
    longint              e, de, acc, s;
    r = '{lcps_pkg::STATUS_SKIP, 1'b0, 16'sd0};
    if (!f.frame_enabled) begin
      blue_count = 0;
      return r;
    end
    if (f.blue_cluster) begin
      if (blue_count < 255) blue_count++;
    end else begin
      blue_count = 0;
    end
    if (f.blue_cluster && blue_count >= stop_need) begin
      line_on  = 1'b0;
      r.status = lcps_pkg::STATUS_STOP;
      return r;
    end
    if (f.yellow_pixel_count == 0) begin
      r.status = lcps_pkg::STATUS_NO_LINE;
      return r;
    end
    pix = 64'(f.yellow_pixel_count);
    if (pix > 64'(lcps_pkg::MAX_REGION_PIXELS_DEF)) pix = 64'(lcps_pkg::MAX_REGION_PIXELS_DEF);
    r.line_found_event = !line_on;
    line_on = 1'b1;
    cx = (64'(f.yellow_x_sum) << lcps_pkg::FRAC_W) / pix;
    if (cx > 64'hF_FFFF) cx = 64'hF_FFFF;
    e = longint'(cx) - longint'({center_px, 8'h00});
    if (hist_fill < lcps_pkg::WINDOW_LENGTH_DEF) hist_fill++;
    else err_total -= err_hist[hist_ptr];
    err_hist[hist_ptr] = e[lcps_pkg::ERR_W-1:0];
    err_total += e;
    hist_ptr = (hist_ptr + 1) % lcps_pkg::WINDOW_LENGTH_DEF;
    de = e - prev_err;
    prev_err = e[lcps_pkg::ERR_W-1:0];
    acc = kp_q24 * e + kidt_q24 * err_total + kd_q24 * de;
    // round half up at the Q.24 boundary
    s = (-acc + 64'sd8388608) >>> lcps_pkg::ROUND_SH;
    if (s > lim_hi || s < lim_lo) clamp_hits++;
    if (s > lim_hi) s = lim_hi;
    if (s < lim_lo) s = lim_lo;
    r.steer_cmd = s[lcps_pkg::STEER_W-1:0];
    r.status = lcps_pkg::STATUS_STEER;
    return r;
  endfunction

  function automatic lcps_pkg::in_item_t random_frame();
    lcps_pkg::in_item_t f;
    int unsigned        pick;
    int                 col;
    f.frame_enabled = 1'b1;
    f.blue_cluster  = (blue_left > 0);
    if (blue_left > 0) blue_left--;
    else if ($urandom_range(0, 19) == 0) blue_left = $urandom_range(1, 12);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      f.frame_enabled = 1'b0;
      f.blue_cluster  = 1'($urandom_range(0, 1));
    end else if (pick < 12) begin
      f.blue_cluster = 1'($urandom_range(0, 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      f.yellow_pixel_count = '0;
      f.yellow_x_sum       = $urandom;
    end else if (pick < 15) begin
      f.yellow_pixel_count = 22'($urandom);
      f.yellow_x_sum       = $urandom;
    end else if (pick < 20) begin
      f.yellow_pixel_count =
        22'($urandom_range(lcps_pkg::MAX_REGION_PIXELS_DEF, 22'h3F_FFFF));
      f.yellow_x_sum       = $urandom;
    end else begin
      f.yellow_pixel_count = 22'($urandom_range(1, 4000));
      if (pick < 30) begin
        col = $urandom_range(0, 2047);
      end else begin
        col = int'(center_px) + int'($urandom_range(0, 400)) - 200;
        if (col < 0) col = 0;
        if (col > 2047) col = 2047;
      end
      f.yellow_x_sum = 32'(f.yellow_pixel_count * col
                     + $urandom_range(0, f.yellow_pixel_count - 1));
    end
    return f;
  endfunction

  task automatic offer_frame(frame_row_t row);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    typed_q.push_back(row);
    in_if.payload <= row.frame;
    in_if.valid   <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(lcps_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      lcps_pkg::CFG_KP:          kp_q24    = val;
      lcps_pkg::CFG_KI_DT:       kidt_q24  = val;
      lcps_pkg::CFG_KD:          kd_q24    = val;
      lcps_pkg::CFG_CENTER:      center_px = val[lcps_pkg::COL_W-1:0];
      lcps_pkg::CFG_STEER_MIN:   lim_lo    = val[lcps_pkg::STEER_W-1:0];
      lcps_pkg::CFG_STEER_MAX:   lim_hi    = val[lcps_pkg::STEER_W-1:0];
      lcps_pkg::CFG_STOP_FRAMES: stop_need = val[lcps_pkg::STOP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] ctr, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] stop);
    put_reg(lcps_pkg::CFG_KP, kp);
    put_reg(lcps_pkg::CFG_KI_DT, ki);
    put_reg(lcps_pkg::CFG_KD, kd);
    put_reg(lcps_pkg::CFG_CENTER, ctr);
    put_reg(lcps_pkg::CFG_STEER_MIN, lo);
    put_reg(lcps_pkg::CFG_STEER_MAX, hi);
    put_reg(lcps_pkg::CFG_STOP_FRAMES, stop);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_settings(int phase);
    case (phase)
      1: load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                       32'hFFFF_8000, 32'h0000_7FFF, 32'd255);
      // crossed limits, zero stop threshold
      2: load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2047,
                       32'h0000_7FFF, 32'hFFFF_8000, 32'd0);
      3: load_settings($urandom_range(0, 32'h200_0000) - 32'h100_0000,
                       $urandom_range(0, 4096) - 32'd2048,
                       $urandom_range(0, 32'h80_0000) - 32'h40_0000,
                       $urandom_range(600, 1000),
                       32'd0 - $urandom_range(256, 9000), $urandom_range(256, 9000),
                       $urandom_range(1, 8));
      4: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
      5: load_settings(32'd0, 32'd0, 32'd0, 32'd770, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'd1);
      default: load_settings(32'(lcps_pkg::KP_RST), 32'(lcps_pkg::KI_DT_RST),
                             32'(lcps_pkg::KD_RST), 32'(lcps_pkg::CENTER_RST),
                             32'(lcps_pkg::STEER_MIN_RST), 32'(lcps_pkg::STEER_MAX_RST),
                             32'd1);
    endcase
  endtask

  always @(posedge clk) begin : result_check
    frame_row_t          row;
    lcps_pkg::out_item_t want, got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        row  = typed_q.pop_front();
        want = steer_model(in_if.payload);
        if (row.fixed) want = row.want;
        steer_q.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        took_result = 1'b1;
        results_seen++;
        status_tally[got.status]++;
        if (got.line_found_event === 1'b1) event_tally++;
        if (steer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing expected: status %0d event %0d steer %0d",
                     results_seen, got.status, got.line_found_event, got.steer_cmd);
        end else begin
          want = steer_q.pop_front();
          if (got.status !== want.status ||
              got.line_found_event !== want.line_found_event ||
              got.steer_cmd !== want.steer_cmd) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected status %0d event %0d steer %0d, got %0d %0d %0d",
                       results_seen, want.status, want.line_found_event, want.steer_cmd,
                       got.status, got.line_found_event, got.steer_cmd);
          end
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (took_result) begin
        took_result = 1'b0;
        hold_left   = sink_steady ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_if.ready <= (hold_left == 0) && !long_hold;
    end
  end

  // one long receiver stall so the block backs up onto its input
  initial begin : long_receiver_hold
    long_hold = 1'b0;
    wait (results_seen >= 120);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : stimulus
    frame_row_t row;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = lcps_pkg::CFG_KP;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    clear_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (dir_rows[i]) offer_frame(dir_rows[i]);

    row = '0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        pick_settings(phase);
      end
      repeat (FRAMES_PER_PHASE) begin
        row.frame = random_frame();
        offer_frame(row);
      end
    end
    in_if.valid <= 1'b0;

    while (steer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d frames under %0d register settings: %0d skipped, %0d stop, %0d steered",
             frames_sent, settings_used + 1, status_tally[lcps_pkg::STATUS_SKIP],
             status_tally[lcps_pkg::STATUS_STOP], status_tally[lcps_pkg::STATUS_STEER]);
    $display("%0d no-line, %0d line-found events, %0d steer values at a limit, %0d mismatches",
             status_tally[lcps_pkg::STATUS_NO_LINE], event_tally, clamp_hits, fail_count);
    if (fail_count == 0 && steer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lcps_pkg.sv
hdl/lcps_stream_if.sv
hdl/lcps_divider.sv
hdl/line_centroid_pid_steering_unit.sv
hdl/lcps_checker.sv
bench/tb_top.sv
